FILE: src/sacd_pkg.sv
package sacd_pkg;

  localparam int WAYS       = 8;
  localparam int SETS       = 64;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 8;
  localparam int TOTAL_W    = 32;
  localparam int OUT_WAY_W  = 3;

  localparam int OFFSET_W   = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int SET_IDX_W  = (SET_W > 0) ? SET_W : 1;
  localparam int TAG_W      = ADDR_W - OFFSET_W - SET_W;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PRIO_W     = CNT_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // words on the two stream channels, rounded up to whole bytes
  localparam int IN_DATA_W  = ((ADDR_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = 1 + OUT_WAY_W + 1 + 3 * TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } sacd_line_t;

  typedef sacd_line_t [WAYS-1:0] sacd_row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
  } sacd_lookup_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } sacd_state_t;

endpackage

FILE: src/sacd_dir_ram.sv
module sacd_dir_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [sacd_pkg::SET_IDX_W-1:0] rd_addr,
  output sacd_pkg::sacd_row_t           rd_data,
  input  logic                          wr_en,
  input  logic [sacd_pkg::SET_IDX_W-1:0] wr_addr,
  input  sacd_pkg::sacd_row_t           wr_data
);

  sacd_pkg::sacd_row_t mem [sacd_pkg::SETS];
  logic [sacd_pkg::SETS-1:0] row_vld_r;
  sacd_pkg::sacd_row_t rd_data_r;

  // a row never written reads as all ways empty with zero counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= row_vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/sacd_lookup.sv
module sacd_lookup (
  input  sacd_pkg::sacd_row_t             row,
  input  logic [sacd_pkg::TAG_W-1:0]      tag,
  output sacd_pkg::sacd_lookup_t          res,
  output sacd_pkg::sacd_row_t             new_row
);

  logic                           hit;
  logic [sacd_pkg::WAY_W-1:0]     hit_way;
  logic [sacd_pkg::WAY_W-1:0]     vict_way;
  logic [sacd_pkg::PRIO_W-1:0]    best;
  logic [sacd_pkg::PRIO_W-1:0]    prio;

  // tag match on valid ways, lowest way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = sacd_pkg::WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && row[w].tag == tag) begin
        hit     = 1'b1;
        hit_way = sacd_pkg::WAY_W'(w);
      end
    end
  end

  // least (valid + count), first way on a tie
  always_comb begin
    best     = '1;
    vict_way = '0;
    prio     = '0;
    for (int w = 0; w < sacd_pkg::WAYS; w++) begin
      prio = sacd_pkg::PRIO_W'(row[w].valid) + sacd_pkg::PRIO_W'(row[w].count);
      if (prio < best) begin
        best     = prio;
        vict_way = sacd_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    new_row     = row;
    res.hit     = hit;
    res.way     = hit ? hit_way : vict_way;
    res.evicted = !hit && row[vict_way].valid;
    if (hit) begin
      if (row[hit_way].count != sacd_pkg::COUNT_MAX) begin
        new_row[hit_way].count = row[hit_way].count + 1'b1;
      end
    end else begin
      new_row[vict_way].valid = 1'b1;
      new_row[vict_way].tag   = tag;
      new_row[vict_way].count = sacd_pkg::CNT_W'(1);
    end
  end

endmodule

FILE: src/set_assoc_cache_lfu_directory_unit.sv
// Tag directory of a set-associative cache with least-frequently-used
// replacement. Each word on the in_ channel is one byte address; each word on
// the out_ channel is the outcome of one access, in order, one per address.
//
// An accepted address reads its whole set (all ways: valid, tag, use count)
// from a single-port-style directory memory with a registered read. In the
// lookup state the block resolves hit or victim, writes the updated set back
// and loads the output register, which then offers the result. A new address
// is not taken until the access before it has finished: each access has a
// memory read step and then a compare and write-back step.
//
// The output register holds a result until out_tready; while it is full the
// next access waits in its compare cycle with its set data held, and in_tready
// stays low. The memory is not cleared: each set has a valid flag in flops
// that reset clears, so the block takes addresses from the first cycle after
// reset. Reset also clears the hit, miss and eviction totals.
module set_assoc_cache_lfu_directory_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sacd_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] address
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] hit, [3:1] way, [4] evicted, [36:5] hit_total, [68:37] miss_total,
  // [100:69] evict_total, rest zero
  output logic [sacd_pkg::OUT_DATA_W-1:0]   out_tdata
);

  sacd_pkg::sacd_state_t state_r, state_nxt;

  logic [sacd_pkg::ADDR_W-1:0]      in_addr;
  logic [sacd_pkg::ADDR_W-1:0]      set_full;
  logic [sacd_pkg::SET_IDX_W-1:0]   in_set;
  logic [sacd_pkg::SET_IDX_W-1:0]   req_set_r;
  logic [sacd_pkg::TAG_W-1:0]       req_tag_r;
  logic                             accept;
  logic                             finish;

  sacd_pkg::sacd_row_t    rd_row;
  sacd_pkg::sacd_row_t    wr_row;
  sacd_pkg::sacd_lookup_t res;

  logic [sacd_pkg::TOTAL_W-1:0] hits_r, hits_nxt;
  logic [sacd_pkg::TOTAL_W-1:0] misses_r, misses_nxt;
  logic [sacd_pkg::TOTAL_W-1:0] evicts_r, evicts_nxt;

  logic                              out_vld_r;
  logic                              out_hit_r;
  logic [sacd_pkg::OUT_WAY_W-1:0]    out_way_r;
  logic                              out_evict_r;
  logic [sacd_pkg::WAY_W+sacd_pkg::OUT_WAY_W-1:0] way_ext;

  assign in_addr  = in_tdata[sacd_pkg::ADDR_W-1:0];
  assign set_full = in_addr >> sacd_pkg::OFFSET_W;
  assign in_set   = sacd_pkg::SET_IDX_W'(set_full % sacd_pkg::SETS);

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      sacd_pkg::ST_IDLE: begin
        accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = sacd_pkg::ST_LOOKUP;
        end
      end
      sacd_pkg::ST_LOOKUP: begin
        // wait until the output register can take the result
        finish = !out_vld_r || out_tready;
        if (finish) begin
          state_nxt = sacd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacd_pkg::ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == sacd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_set_r <= in_set;
      req_tag_r <= sacd_pkg::TAG_W'(in_addr >> (sacd_pkg::OFFSET_W + sacd_pkg::SET_W));
    end
  end

  sacd_dir_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (rd_row),
    .wr_en   (finish),
    .wr_addr (req_set_r),
    .wr_data (wr_row)
  );

  sacd_lookup u_lookup (
    .row     (rd_row),
    .tag     (req_tag_r),
    .res     (res),
    .new_row (wr_row)
  );

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (finish) begin
      if (res.hit) begin
        hits_nxt = hits_r + 1'b1;
      end else begin
        misses_nxt = misses_r + 1'b1;
      end
      if (res.evicted) begin
        evicts_nxt = evicts_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  assign way_ext = {{sacd_pkg::OUT_WAY_W{1'b0}}, res.way};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit_r   <= res.hit;
      out_way_r   <= way_ext[sacd_pkg::OUT_WAY_W-1:0];
      out_evict_r <= res.evicted;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = sacd_pkg::OUT_DATA_W'({evicts_r, misses_r, hits_r,
                                             out_evict_r, out_way_r, out_hit_r});

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == sacd_pkg::ST_LOOKUP)
    else $error("accepted address did not start a lookup");

  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == sacd_pkg::ST_LOOKUP)
    else $error("result appeared without a lookup");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_hit_r && out_evict_r))
    else $error("hit reported with eviction");

  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |=> $stable(hits_r) && $stable(misses_r)
                                  && $stable(evicts_r))
    else $error("totals changed while result stalled");

endmodule

FILE: bench/tb_set_assoc_cache_lfu_directory_unit.sv
module tb_set_assoc_cache_lfu_directory_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    bit                           hit;
    bit [sacd_pkg::OUT_WAY_W-1:0] way;
    bit                           evicted;
    bit [sacd_pkg::TOTAL_W-1:0]   hit_total;
    bit [sacd_pkg::TOTAL_W-1:0]   miss_total;
    bit [sacd_pkg::TOTAL_W-1:0]   evict_total;
  } access_outcome_t;

  // lfu directory predictor plus in-order store of expected outcomes
  class lfu_scoreboard;
    bit [sacd_pkg::TAG_W-1:0]   tags  [sacd_pkg::SETS][sacd_pkg::WAYS];
    bit                         valid [sacd_pkg::SETS][sacd_pkg::WAYS];
    bit [sacd_pkg::CNT_W-1:0]   uses  [sacd_pkg::SETS][sacd_pkg::WAYS];
    bit [sacd_pkg::TOTAL_W-1:0] hit_cnt;
    bit [sacd_pkg::TOTAL_W-1:0] miss_cnt;
    bit [sacd_pkg::TOTAL_W-1:0] evict_cnt;
    access_outcome_t            outcome_q[$];
    int                         errors;

    function int pending();
      return outcome_q.size();
    endfunction

    function void note_address(logic [sacd_pkg::ADDR_W-1:0] addr);
      bit [sacd_pkg::SET_W-1:0] s;
      bit [sacd_pkg::TAG_W-1:0] t;
      int                       hit_way;
      int                       victim;
      int unsigned              prio;
      int unsigned              best;
      access_outcome_t          o;
      s = addr[sacd_pkg::OFFSET_W +: sacd_pkg::SET_W];
      t = addr[sacd_pkg::ADDR_W-1 -: sacd_pkg::TAG_W];
      o = '{default: 0};
      hit_way = 0;
      // only valid ways take part in the tag match, lowest way wins
      for (int i = 0; i < sacd_pkg::WAYS; i++) begin
        if (!o.hit && valid[s][i] && tags[s][i] == t) begin
          o.hit = 1'b1;
          hit_way = i;
        end
      end
      if (o.hit) begin
        if (uses[s][hit_way] != sacd_pkg::COUNT_MAX) uses[s][hit_way]++;
        hit_cnt++;
        o.way = sacd_pkg::OUT_WAY_W'(hit_way);
      end else begin
        best = '1;
        victim = 0;
        for (int i = 0; i < sacd_pkg::WAYS; i++) begin
          prio = int'(valid[s][i]) + int'(uses[s][i]);
          if (prio < best) begin
            best = prio;
            victim = i;
          end
        end
        if (valid[s][victim]) begin
          o.evicted = 1'b1;
          evict_cnt++;
        end
        valid[s][victim] = 1'b1;
        tags[s][victim] = t;
        uses[s][victim] = sacd_pkg::CNT_W'(1);
        miss_cnt++;
        o.way = sacd_pkg::OUT_WAY_W'(victim);
      end
      o.hit_total = hit_cnt;
      o.miss_total = miss_cnt;
      o.evict_total = evict_cnt;
      outcome_q.push_back(o);
    endfunction

    function void compare_field(string field, logic [sacd_pkg::TOTAL_W-1:0] want,
                                logic [sacd_pkg::TOTAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(logic [sacd_pkg::OUT_DATA_W-1:0] word);
      access_outcome_t e;
      if (outcome_q.size() == 0) begin
        $error("result word %h arrived with no access pending", word);
        errors++;
        return;
      end
      e = outcome_q.pop_front();
      compare_field("hit", sacd_pkg::TOTAL_W'(e.hit), sacd_pkg::TOTAL_W'(word[0]));
      compare_field("way", sacd_pkg::TOTAL_W'(e.way),
                    sacd_pkg::TOTAL_W'(word[1 +: sacd_pkg::OUT_WAY_W]));
      compare_field("evicted", sacd_pkg::TOTAL_W'(e.evicted),
                    sacd_pkg::TOTAL_W'(word[1 + sacd_pkg::OUT_WAY_W]));
      compare_field("hit_total", e.hit_total, word[5 +: sacd_pkg::TOTAL_W]);
      compare_field("miss_total", e.miss_total,
                    word[5 + sacd_pkg::TOTAL_W +: sacd_pkg::TOTAL_W]);
      compare_field("evict_total", e.evict_total,
                    word[5 + 2 * sacd_pkg::TOTAL_W +: sacd_pkg::TOTAL_W]);
      compare_field("pad", '0,
                    sacd_pkg::TOTAL_W'(word[sacd_pkg::OUT_DATA_W-1:sacd_pkg::OUT_FLD_W]));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [sacd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sacd_pkg::OUT_DATA_W-1:0] out_tdata;

  lfu_scoreboard sb;
  int            tx_gap_pct;
  int            rx_stall_pct;
  int            stall_left = 0;
  int            cycle_cnt = 0;

  set_assoc_cache_lfu_directory_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_set_assoc_cache_lfu_directory_unit: FAIL");
      $finish;
    end
  end

  // inputs are noted before results so a word never outruns its address
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_address(in_tdata[sacd_pkg::ADDR_W-1:0]);
      if (out_tvalid && out_tready) sb.check_outcome(out_tdata);
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && $urandom_range(0, 99) < rx_stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 16) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic rest(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_addr(input logic [sacd_pkg::ADDR_W-1:0] a);
    if ($urandom_range(0, 99) < tx_gap_pct) rest($urandom_range(1, 16));
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    rest(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [sacd_pkg::ADDR_W-1:0] line_addr(
    logic [sacd_pkg::TAG_W-1:0] t,
    logic [sacd_pkg::SET_W-1:0] s,
    logic [sacd_pkg::OFFSET_W-1:0] o);
    return {t, s, o};
  endfunction

  initial begin
    logic [sacd_pkg::SET_W-1:0]  hot_sets[4];
    logic [sacd_pkg::TAG_W-1:0]  tag_pool[12];
    logic [sacd_pkg::TAG_W-1:0]  sat_tag;
    logic [sacd_pkg::SET_W-1:0]  s;
    logic [sacd_pkg::ADDR_W-1:0] addr;
    logic [sacd_pkg::ADDR_W-1:0] last_addr;
    int                          kind;

    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_gap_pct = 15;
    rx_stall_pct = 15;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tag zero on an empty set must miss, then hit
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'hFFFF_FFC0);
    // fill set 1, bump one way, then force victims by least use
    for (int i = 1; i <= sacd_pkg::WAYS; i++) begin
      send_addr(line_addr(sacd_pkg::TAG_W'(i), 6'd1, 6'd0));
    end
    send_addr(line_addr(20'd3, 6'd1, 6'h3F));
    send_addr(line_addr(20'd9, 6'd1, 6'd0));
    send_addr(line_addr(20'd10, 6'd1, 6'd4));
    send_addr(line_addr(20'd1, 6'd1, 6'd8));
    send_addr(32'hAAAA_AAAA);
    send_addr(32'h5555_5555);

    for (int i = 0; i < 4; i++) hot_sets[i] = sacd_pkg::SET_W'($urandom);
    for (int i = 0; i < 12; i++) tag_pool[i] = sacd_pkg::TAG_W'($urandom);
    last_addr = 32'h0;

    for (int i = 0; i < 1300; i++) begin
      if (i % 200 == 0) begin
        tx_gap_pct = $urandom_range(0, 2) * 15;
        rx_stall_pct = $urandom_range(0, 2) * 15;
      end
      if (i >= 1100) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      if (i == 650) drain();
      if (i == 400) begin
        // drive one line's use count past its top, then flood the set
        s = sacd_pkg::SET_W'($urandom);
        sat_tag = sacd_pkg::TAG_W'($urandom);
        for (int j = 0; j < 270; j++) begin
          send_addr(line_addr(sat_tag, s, sacd_pkg::OFFSET_W'($urandom)));
        end
        for (int j = 0; j < 12; j++) begin
          send_addr(line_addr(sacd_pkg::TAG_W'($urandom), s,
                              sacd_pkg::OFFSET_W'($urandom)));
        end
        send_addr(line_addr(sat_tag, s, sacd_pkg::OFFSET_W'($urandom)));
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        s = ($urandom_range(0, 3) == 0) ? sacd_pkg::SET_W'($urandom)
                                        : hot_sets[$urandom_range(0, 3)];
        addr = line_addr(tag_pool[$urandom_range(0, $urandom_range(0, 11))], s,
                         sacd_pkg::OFFSET_W'($urandom));
      end else if (kind < 85) begin
        addr = last_addr;
      end else begin
        addr = $urandom;
      end
      send_addr(addr);
      last_addr = addr;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_set_assoc_cache_lfu_directory_unit: PASS");
    end else begin
      $display("tb_set_assoc_cache_lfu_directory_unit: FAIL");
    end
    $finish;
  end

endmodule
